// ----- design/scfp_pkg.sv -----
// ----------------------------------------------------------------------------
// scfp_pkg: shared definitions for the serial command frame parser
// Frame geometry, byte codes, command codes and the frame item type that
// travels from the front end to the decoder.
// ----------------------------------------------------------------------------
package scfp_pkg;

    // Frame store geometry
    localparam int FRAME_BYTES = 8;
    localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
    localparam int IDX_W       = $clog2(FRAME_BYTES);

    // Frame queue between front end and decoder
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Byte codes
    localparam logic [7:0] START_BYTE = 8'hEE;
    localparam logic [7:0] END_BYTE   = 8'hFF;
    localparam logic [7:0] HDR_ENABLE = 8'h11;
    localparam logic [7:0] SUB_ENABLE = 8'h04;
    localparam logic [7:0] ENABLE_ON  = 8'h0F;
    localparam logic [7:0] ENABLE_OFF = 8'h00;
    localparam logic [7:0] PAD_BYTE   = 8'h00;
    localparam logic [7:0] HDR_RATE   = 8'h21;
    localparam logic [7:0] HDR_MODE   = 8'h31;
    localparam logic [7:0] SUB_MODE   = 8'h06;
    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [7:0] DIGIT_NINE = 8'h39;
    localparam logic [6:0] MODE_MAX   = 7'd30;

    // Frame lengths that can carry a command
    localparam logic [CNT_W-1:0] LEN_SHORT = CNT_W'(6);
    localparam logic [CNT_W-1:0] LEN_LONG  = CNT_W'(7);

    // Command codes
    typedef enum logic [1:0] {
        CMD_ENABLE = 2'd0,
        CMD_RATE   = 2'd1,
        CMD_MODE   = 2'd2
    } cmd_t;

    // Candidate frame: bytes one to five, and whether the frame is seven long
    typedef struct packed {
        logic       len7;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [7:0] b4;
        logic [7:0] b5;
    } frame_t;

endpackage

// ----- design/scfp_front.sv -----
// ----------------------------------------------------------------------------
// scfp_front: frame assembler
// Stores received bytes, tracks the byte count and, when an end byte closes
// a frame of a length that can hold a command, pushes the frame to the queue.
// ----------------------------------------------------------------------------
module scfp_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            rx_byte,
    output logic                  push_valid,
    output scfp_pkg::frame_t      push_data
);
    import scfp_pkg::*;

    logic [7:0]       store_reg [FRAME_BYTES];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] cnt_base;
    logic [CNT_W-1:0] cnt_stored;
    logic             is_start;
    logic             room;
    logic             end_hit;

    // Count update: start byte restarts, bytes kept while there is room
    always_comb
    begin
        is_start   = (rx_byte == START_BYTE);
        cnt_base   = is_start ? '0 : count_reg;
        room       = (cnt_base < CNT_W'(FRAME_BYTES));
        cnt_stored = room ? cnt_base + CNT_W'(1) : cnt_base;
        end_hit    = (rx_byte == END_BYTE) && (cnt_stored >= CNT_W'(2));
        count_next = end_hit ? '0 : cnt_stored;
    end

    // Frame candidate: end byte was stored, length six or seven, start held
    always_comb
    begin
        push_valid = accept && end_hit && room
                     && ((cnt_stored == LEN_SHORT) || (cnt_stored == LEN_LONG))
                     && (store_reg[0] == START_BYTE);
        push_data.len7 = (cnt_stored == LEN_LONG);
        push_data.b1   = store_reg[1];
        push_data.b2   = store_reg[2];
        push_data.b3   = store_reg[3];
        push_data.b4   = store_reg[4];
        push_data.b5   = store_reg[5];
    end

    // Byte count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    // Frame store: no reset, only entries of the current frame are read
    always_ff @(posedge clk)
    begin
        if (accept && room)
        begin
            store_reg[cnt_base[IDX_W-1:0]] <= rx_byte;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FRAME_BYTES))
        else $error("byte count beyond frame store");

    a_start_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (rx_byte == START_BYTE) |=> count_reg == CNT_W'(1))
        else $error("start byte did not restart the frame");
`endif

endmodule

// ----- design/scfp_queue.sv -----
// ----------------------------------------------------------------------------
// scfp_queue: frame queue
// Short first-in first-out buffer of candidate frames between the front end
// and the decoder.
// ----------------------------------------------------------------------------
module scfp_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    input  scfp_pkg::frame_t      push_data,
    output logic                  full,
    input  logic                  pop,
    output logic                  head_valid,
    output scfp_pkg::frame_t      head_data
);
    import scfp_pkg::*;

    frame_t            slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    // Status
    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && !full;
    assign do_pop     = pop && head_valid;

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    // Slot storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push_valid && full))
        else $error("frame pushed into full queue");
`endif

endmodule

// ----- design/scfp_back.sv -----
// ----------------------------------------------------------------------------
// scfp_back: command decoder
// Takes candidate frames from the queue, decodes enable, rate and mode
// commands and holds the result in an output register until it is taken.
// ----------------------------------------------------------------------------
module scfp_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  scfp_pkg::frame_t      head_data,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            command,
    output logic [13:0]           value
);
    import scfp_pkg::*;

    logic        out_valid_reg;
    logic        out_valid_next;
    cmd_t        command_reg;
    logic [13:0] value_reg;
    logic        hit;
    cmd_t        cmd_dec;
    logic [13:0] val_dec;
    logic [3:0]  d2, d3, d4, d5;
    logic        enable_hdr;
    logic        rate_ok;
    logic [6:0]  mode_num;
    logic        mode_ok;

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= DIGIT_ZERO) && (c <= DIGIT_NINE);
    endfunction

    function automatic logic [3:0] digit_of(input logic [7:0] c);
        logic [7:0] d;
        d = c - DIGIT_ZERO;
        digit_of = d[3:0];
    endfunction

    // Decode of the frame at the head of the queue
    always_comb
    begin
        d2 = digit_of(head_data.b2);
        d3 = digit_of(head_data.b3);
        d4 = digit_of(head_data.b4);
        d5 = digit_of(head_data.b5);

        enable_hdr = !head_data.len7 && (head_data.b1 == HDR_ENABLE)
                     && (head_data.b2 == SUB_ENABLE) && (head_data.b4 == PAD_BYTE);

        rate_ok = (head_data.b1 == HDR_RATE) && is_digit(head_data.b2)
                  && is_digit(head_data.b3) && is_digit(head_data.b4)
                  && (!head_data.len7 || is_digit(head_data.b5));

        mode_num = 7'(d3) * 7'd10 + 7'(d4);
        mode_ok  = !head_data.len7 && (head_data.b1 == HDR_MODE)
                   && (head_data.b2 == SUB_MODE) && is_digit(head_data.b3)
                   && is_digit(head_data.b4) && (mode_num != 7'd0)
                   && (mode_num <= MODE_MAX);

        hit     = 1'b0;
        cmd_dec = CMD_ENABLE;
        val_dec = '0;
        if (enable_hdr && (head_data.b3 == ENABLE_ON))
        begin
            hit     = 1'b1;
            val_dec = 14'd1;
        end
        else if (enable_hdr && (head_data.b3 == ENABLE_OFF))
        begin
            hit = 1'b1;
        end
        else if (rate_ok)
        begin
            hit     = 1'b1;
            cmd_dec = CMD_RATE;
            if (head_data.len7)
            begin
                val_dec = 14'(d2) * 14'd1000 + 14'(d3) * 14'd100
                          + 14'(d4) * 14'd10 + 14'(d5);
            end
            else
            begin
                val_dec = 14'(d2) * 14'd100 + 14'(d3) * 14'd10 + 14'(d4);
            end
        end
        else if (mode_ok)
        begin
            hit     = 1'b1;
            cmd_dec = CMD_MODE;
            val_dec = 14'(mode_num - 7'd1);
        end
    end

    // Take a frame whenever the output register is free or being emptied
    always_comb
    begin
        pop            = head_valid && (!out_valid_reg || !out_stall);
        out_valid_next = pop ? hit : (out_valid_reg && out_stall);
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && hit)
        begin
            command_reg <= cmd_dec;
            value_reg   <= val_dec;
        end
    end

    assign out_valid = out_valid_reg;
    assign command   = command_reg;
    assign value     = value_reg;

`ifndef SYNTHESIS
    a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (command_reg == CMD_MODE) |-> value_reg < 14'd30)
        else $error("mode index out of range");

    a_enable_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (command_reg == CMD_ENABLE) |-> value_reg <= 14'd1)
        else $error("enable flag out of range");

    a_rate_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (command_reg == CMD_RATE) |-> value_reg <= 14'd9999)
        else $error("rate out of range");
`endif

endmodule

// ----- design/serial_command_frame_parser_top.sv -----
// ----------------------------------------------------------------------------
// serial_command_frame_parser_top: serial command frame parser
// Assembles received bytes into frames and decodes enable, rate and mode
// commands. Front end, frame queue and decoder each stall on their own.
// A decoded frame reaches out_valid through the frame queue and then the output register.
// Throughput: one byte per cycle while the queue is not full; stall rises only while the queue is full.
// Reset clears the byte count, the queue and the output valid flag; the
// frame store is not cleared, as only bytes of the current frame are read.
// ----------------------------------------------------------------------------
module serial_command_frame_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  command,
    output logic [13:0] value
);
    import scfp_pkg::*;

    logic   accept;
    logic   push_valid;
    frame_t push_data;
    logic   full;
    logic   pop;
    logic   head_valid;
    frame_t head_data;

    // Input handshake
    assign in_stall = full;
    assign accept   = in_valid && !full;

    scfp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .rx_byte    (rx_byte),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    scfp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    scfp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .command    (command),
        .value      (value)
    );

endmodule
